// File: rtl/core/fge_pkg.sv
package fge_pkg;

  // Coordinate width of origins and pixel positions
  localparam int CoordBits = 10;
  // Width of the panel size registers
  localparam int PanelBits = 11;
  localparam int ColorBits = 16;
  localparam int FontBits  = 8;
  localparam int IdxBits   = 5;
  // Compare width that holds both an extended coordinate sum and a panel size
  localparam int CmpBits   = (CoordBits + 1 > PanelBits) ? CoordBits + 1 : PanelBits;
  // Offset of the right-hand half of a wide glyph
  localparam int WideColStep = 8;

  // Request queue between front and back
  localparam int QueueDepth   = 2;
  localparam int QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntBits = $clog2(QueueDepth + 1);

  // APB register map
  localparam int AddrBits = 5;
  localparam logic [2:0] RegFgColor  = 3'd0;
  localparam logic [2:0] RegBgColor  = 3'd1;
  localparam logic [2:0] RegBgEnable = 3'd2;
  localparam logic [2:0] RegPanelW   = 3'd3;
  localparam logic [2:0] RegPanelH   = 3'd4;

  localparam logic [ColorBits-1:0] FgColorReset = 16'h0000;
  localparam logic [ColorBits-1:0] BgColorReset = 16'hFFFF;
  localparam logic [PanelBits-1:0] PanelWReset  = 11'd240;
  localparam logic [PanelBits-1:0] PanelHReset  = 11'd320;

  typedef struct packed {
    logic [ColorBits-1:0] fg_color;
    logic [ColorBits-1:0] bg_color;
    logic                 bg_enable;
    logic [PanelBits-1:0] panel_w;
    logic [PanelBits-1:0] panel_h;
  } cfg_t;

  // One classified glyph byte; mask/set bit k is column offset k
  typedef struct packed {
    logic [CoordBits-1:0] row;
    logic [CoordBits-1:0] col0;
    logic [FontBits-1:0]  set;
    logic [FontBits-1:0]  mask;
  } glyph_req_t;

endpackage

// File: rtl/core/fge_front.sv
module fge_front import fge_pkg::*; (
  input  logic                 font_valid_i,
  output logic                 font_ready_o,
  input  logic [FontBits-1:0]  font_bits_i,
  input  logic [IdxBits-1:0]   byte_index_i,
  input  logic                 wide_glyph_i,
  input  logic [CoordBits-1:0] origin_row_i,
  input  logic [CoordBits-1:0] origin_col_i,
  input  cfg_t                 cfg_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output glyph_req_t           req_o
);

  logic [CoordBits:0]   row_sum;
  logic [CoordBits:0]   col0_sum;
  logic [IdxBits-1:0]   row_off;
  logic                 row_ok;
  logic [FontBits-1:0]  mask;

  always_comb begin
    row_off  = wide_glyph_i ? (byte_index_i >> 1) : byte_index_i;
    row_sum  = {1'b0, origin_row_i} + (CoordBits + 1)'(row_off);
    col0_sum = {1'b0, origin_col_i} +
               ((wide_glyph_i && byte_index_i[0]) ? (CoordBits + 1)'(WideColStep)
                                                  : '0);
    row_ok   = !row_sum[CoordBits] && (CmpBits'(row_sum) < CmpBits'(cfg_i.panel_w));
  end

  // Per column offset: painted (set, or background on) and inside the panel
  always_comb begin
    logic [CoordBits:0] col_k;
    for (int k = 0; k < FontBits; k++) begin
      col_k   = col0_sum + (CoordBits + 1)'(k);
      mask[k] = (font_bits_i[FontBits-1-k] || cfg_i.bg_enable) && row_ok &&
                !col_k[CoordBits] && (CmpBits'(col_k) < CmpBits'(cfg_i.panel_h));
    end
  end

  always_comb begin
    for (int k = 0; k < FontBits; k++) begin
      req_o.set[k] = font_bits_i[FontBits-1-k];
    end
    req_o.row  = row_sum[CoordBits-1:0];
    req_o.col0 = col0_sum[CoordBits-1:0];
    req_o.mask = mask;
  end

  // A byte with nothing visible is consumed here and never queued
  assign font_ready_o = !q_full_i;
  assign push_o       = font_valid_i && !q_full_i && (mask != '0);

endmodule

// File: rtl/core/fge_queue.sv
module fge_queue import fge_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  glyph_req_t push_req_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output glyph_req_t pop_req_o
);

  glyph_req_t                mem_q [QueueDepth];
  logic [QueuePtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntBits-1:0]   cnt_q, cnt_d;

  assign full_o    = (cnt_q == QueueCntBits'(QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_req_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && cnt_q == '0))
    else $error("fge_queue: pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("fge_queue: push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cnt_q <= QueueCntBits'(QueueDepth))
    else $error("fge_queue: fill count beyond depth");

endmodule

// File: rtl/core/fge_back.sv
module fge_back import fge_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 q_valid_i,
  input  glyph_req_t           q_req_i,
  output logic                 pop_o,
  output logic                 pixel_valid_o,
  input  logic                 pixel_ready_i,
  output logic [CoordBits-1:0] pixel_row_o,
  output logic [CoordBits-1:0] pixel_col_o,
  output logic [ColorBits-1:0] pixel_color_o,
  output logic                 last_pixel_o
);

  glyph_req_t                cur_q, cur_d;
  logic                      cur_valid_q, cur_valid_d;
  logic [FontBits-1:0]       rem_q, rem_d;
  logic                      out_valid_q, out_valid_d;
  logic [CoordBits-1:0]      row_q, col_q;
  logic [ColorBits-1:0]      color_q;
  logic                      last_q;

  logic [FontBits-1:0]       pick;
  logic [$clog2(FontBits)-1:0] pick_k;
  logic [FontBits-1:0]       rem_left;
  logic                      is_last;
  logic                      adv;

  // Lowest remaining column offset goes first
  always_comb begin
    pick   = '0;
    pick_k = '0;
    for (int k = FontBits - 1; k >= 0; k--) begin
      if (rem_q[k]) begin
        pick   = '0;
        pick[k] = 1'b1;
        pick_k = ($clog2(FontBits))'(k);
      end
    end
    rem_left = rem_q & ~pick;
    is_last  = (rem_left == '0);
  end

  assign adv   = cur_valid_q && (!out_valid_q || pixel_ready_i);
  assign pop_o = q_valid_i && (!cur_valid_q || (adv && is_last));

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      rem_d       = rem_left;
      out_valid_d = 1'b1;
      if (is_last) begin
        cur_valid_d = 1'b0;
      end
    end else if (pixel_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      cur_d       = q_req_i;
      cur_valid_d = 1'b1;
      rem_d       = q_req_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (adv) begin
      row_q   <= cur_q.row;
      col_q   <= cur_q.col0 + CoordBits'(pick_k);
      color_q <= cur_q.set[pick_k] ? cfg_i.fg_color : cfg_i.bg_color;
      last_q  <= is_last;
    end
  end

  assign pixel_valid_o = out_valid_q;
  assign pixel_row_o   = row_q;
  assign pixel_col_o   = col_q;
  assign pixel_color_o = color_q;
  assign last_pixel_o  = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_valid_q |-> rem_q != '0)
    else $error("fge_back: active request with no pixels left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (q_valid_i && !cur_valid_q) |=> cur_valid_q)
    else $error("fge_back: queued request not taken by idle back end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> (CmpBits'(col_q) < CmpBits'(cfg_i.panel_h)) &&
                                   (CmpBits'(row_q) < CmpBits'(cfg_i.panel_w)))
    else $error("fge_back: pixel outside panel");

endmodule

// File: rtl/core/font_glyph_row_expander_top.sv
// Glyph row expander: each accepted request carries one font bitmap byte
// (leftmost pixel in bit 7), its index within the glyph, a narrow/wide flag
// and the glyph origin, and yields up to eight pixel writes in column-offset
// order, the final one flagged with last_pixel_o. A byte that has no visible
// pixel is swallowed and yields nothing. The pixel channel moves one write
// per cycle while the receiver is ready, so a byte yields one write per
// visible pixel, 0 to 8. The front end classifies a byte in the cycle it
// is taken and queues it (two deep), so new requests are taken while the
// back end still walks an earlier byte and while a finished pixel waits in
// the output register. Colours, background enable and panel size sit in
// APB registers (fg 0x00, bg 0x04, bg enable 0x08, width 0x0C, height
// 0x10) and should only be written with the block idle.
module font_glyph_row_expander_top import fge_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrBits-1:0]  paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Font byte requests
  input  logic                 font_valid_i,
  output logic                 font_ready_o,
  input  logic [FontBits-1:0]  font_bits_i,
  input  logic [IdxBits-1:0]   byte_index_i,
  input  logic                 wide_glyph_i,
  input  logic [CoordBits-1:0] origin_row_i,
  input  logic [CoordBits-1:0] origin_col_i,
  // Pixel writes
  output logic                 pixel_valid_o,
  input  logic                 pixel_ready_i,
  output logic [CoordBits-1:0] pixel_row_o,
  output logic [CoordBits-1:0] pixel_col_o,
  output logic [ColorBits-1:0] pixel_color_o,
  output logic                 last_pixel_o
);

  cfg_t       cfg_q;
  logic [2:0] reg_sel;
  logic       cfg_wr;

  logic       q_full;
  logic       q_valid;
  logic       push;
  logic       pop;
  glyph_req_t push_req;
  glyph_req_t pop_req;

  // --- configuration registers ---
  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg_color  <= FgColorReset;
      cfg_q.bg_color  <= BgColorReset;
      cfg_q.bg_enable <= 1'b1;
      cfg_q.panel_w   <= PanelWReset;
      cfg_q.panel_h   <= PanelHReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegFgColor:  cfg_q.fg_color  <= pwdata[ColorBits-1:0];
        RegBgColor:  cfg_q.bg_color  <= pwdata[ColorBits-1:0];
        RegBgEnable: cfg_q.bg_enable <= pwdata[0];
        RegPanelW:   cfg_q.panel_w   <= pwdata[PanelBits-1:0];
        RegPanelH:   cfg_q.panel_h   <= pwdata[PanelBits-1:0];
        default: ;
      endcase
    end
  end

  // Read-back; unmapped addresses read as zero
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      RegFgColor:  prdata = 32'(cfg_q.fg_color);
      RegBgColor:  prdata = 32'(cfg_q.bg_color);
      RegBgEnable: prdata = 32'(cfg_q.bg_enable);
      RegPanelW:   prdata = 32'(cfg_q.panel_w);
      RegPanelH:   prdata = 32'(cfg_q.panel_h);
      default:     prdata = '0;
    endcase
  end

  // --- front: placement and visibility of the eight pixels ---
  fge_front u_front (
    .font_valid_i (font_valid_i),
    .font_ready_o (font_ready_o),
    .font_bits_i  (font_bits_i),
    .byte_index_i (byte_index_i),
    .wide_glyph_i (wide_glyph_i),
    .origin_row_i (origin_row_i),
    .origin_col_i (origin_col_i),
    .cfg_i        (cfg_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .req_o        (push_req)
  );

  // --- decoupling queue ---
  fge_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_req_o  (pop_req)
  );

  // --- back: one pixel write per cycle into the output register while the receiver is ready ---
  fge_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_req_i       (pop_req),
    .pop_o         (pop),
    .pixel_valid_o (pixel_valid_o),
    .pixel_ready_i (pixel_ready_i),
    .pixel_row_o   (pixel_row_o),
    .pixel_col_o   (pixel_col_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fge_pkg::*;

  // Half of the 12 ns clock period
  localparam int HalfPeriod = 6;
  // Width of the coordinate space; a sum at or above it is off the map
  localparam int CoordSpan = 1 << CoordBits;
  // Cycles the receiver holds off once so that the queue fills and stalls the input
  localparam int LongHoldCycles = 300;
  // Cycles given to swallowed requests still in flight after the last pixel
  localparam int SettleCycles = 24;

  // One font byte request as offered to the block
  typedef struct packed {
    logic [FontBits-1:0]  bits;
    logic [IdxBits-1:0]   idx;
    logic                 wide;
    logic [CoordBits-1:0] orow;
    logic [CoordBits-1:0] ocol;
  } font_req_t;

  // One pixel write as produced by the block
  typedef struct packed {
    logic [CoordBits-1:0] row;
    logic [CoordBits-1:0] col;
    logic [ColorBits-1:0] color;
    logic                 last;
  } pixel_t;

  // Own copy of the register file, expansion of each taken byte into the
  // pixel writes it should give, and an in-order check of those writes.
  class pixel_board;
    logic [ColorBits-1:0] fg;
    logic [ColorBits-1:0] bg;
    logic                 bg_en;
    logic [PanelBits-1:0] panel_w;
    logic [PanelBits-1:0] panel_h;
    pixel_t               due_pixels[$];
    int                   errors;
    int                   bytes_seen;
    int                   pixels_seen;

    function new();
      fg      = FgColorReset;
      bg      = BgColorReset;
      bg_en   = 1'b1;
      panel_w = PanelWReset;
      panel_h = PanelHReset;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        RegFgColor:  fg      = val[ColorBits-1:0];
        RegBgColor:  bg      = val[ColorBits-1:0];
        RegBgEnable: bg_en   = val[0];
        RegPanelW:   panel_w = val[PanelBits-1:0];
        RegPanelH:   panel_h = val[PanelBits-1:0];
        default: ;
      endcase
    endfunction

    function void expand_byte(font_req_t req);
      int unsigned row;
      int unsigned col0;
      int unsigned col;
      int          first;
      pixel_t      px;
      bytes_seen++;
      if (req.wide) begin
        row  = 32'(req.orow) + 32'(req.idx >> 1);
        col0 = 32'(req.ocol) + (req.idx[0] ? 32'(WideColStep) : 32'd0);
      end else begin
        row  = 32'(req.orow) + 32'(req.idx);
        col0 = 32'(req.ocol);
      end
      first = due_pixels.size();
      for (int k = 0; k < 8; k++) begin
        col = col0 + 32'(k);
        if (!req.bits[7-k] && !bg_en) continue;
        // off the coordinate map or off the panel
        if (row >= CoordSpan || col >= CoordSpan) continue;
        if (row >= 32'(panel_w) || col >= 32'(panel_h)) continue;
        px.row   = row[CoordBits-1:0];
        px.col   = col[CoordBits-1:0];
        px.color = req.bits[7-k] ? fg : bg;
        px.last  = 1'b0;
        due_pixels.push_back(px);
      end
      if (due_pixels.size() > first) begin
        px = due_pixels.pop_back();
        px.last = 1'b1;
        due_pixels.push_back(px);
      end
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0d ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
    endfunction

    function void take_pixel(pixel_t got);
      pixel_t want;
      pixels_seen++;
      if (due_pixels.size() == 0) begin
        errors++;
        $display({"%0d ns: pixel with none expected, expected nothing, ",
                  "got row %0d col %0d colour 0x%h last %0b"},
                 $time, got.row, got.col, got.color, got.last);
        return;
      end
      want = due_pixels.pop_front();
      compare("pixel_row", 32'(want.row), 32'(got.row));
      compare("pixel_col", 32'(want.col), 32'(got.col));
      compare("pixel_color", 32'(want.color), 32'(got.color));
      compare("last_pixel", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrBits-1:0]  paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 font_valid_i;
  logic                 font_ready_o;
  logic [FontBits-1:0]  font_bits_i;
  logic [IdxBits-1:0]   byte_index_i;
  logic                 wide_glyph_i;
  logic [CoordBits-1:0] origin_row_i;
  logic [CoordBits-1:0] origin_col_i;
  logic                 pixel_valid_o;
  logic                 pixel_ready_i;
  logic [CoordBits-1:0] pixel_row_o;
  logic [CoordBits-1:0] pixel_col_o;
  logic [ColorBits-1:0] pixel_color_o;
  logic                 last_pixel_o;

  pixel_board sb;
  // raised by the stimulus, picked up and cleared by the pixel sink
  bit hold_pixels;
  int settings_seen;

  font_glyph_row_expander_top dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .font_valid_i,
    .font_ready_o,
    .font_bits_i,
    .byte_index_i,
    .wide_glyph_i,
    .origin_row_i,
    .origin_col_i,
    .pixel_valid_o,
    .pixel_ready_i,
    .pixel_row_o,
    .pixel_col_o,
    .pixel_color_o,
    .last_pixel_o
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Run limit: the slowest legal run stays well inside a tenth of this
  initial begin : watchdog
    #5_000_000;
    $display("FAIL font_glyph_row_expander_top");
    $finish;
  end

  function automatic font_req_t make_req(logic [FontBits-1:0] bits, int idx, bit wide,
                                         int orow, int ocol);
    font_req_t r;
    r.bits = bits;
    r.idx  = idx[IdxBits-1:0];
    r.wide = wide;
    r.orow = orow[CoordBits-1:0];
    r.ocol = ocol[CoordBits-1:0];
    return r;
  endfunction

  // Origins mostly land on the panel, some near the top of the coordinate
  // range (overflow), some anywhere.
  function automatic logic [CoordBits-1:0] pick_origin(int unsigned span);
    int unsigned top;
    top = (span == 0) ? 0 : ((span > CoordSpan) ? CoordSpan - 1 : span - 1);
    case ($urandom_range(0, 3))
      0:       return CoordBits'($urandom_range(CoordSpan - 16, CoordSpan - 1));
      1:       return CoordBits'($urandom_range(0, CoordSpan - 1));
      default: return CoordBits'($urandom_range(0, top));
    endcase
  endfunction

  function automatic font_req_t random_req();
    font_req_t r;
    case ($urandom_range(0, 4))
      0:       r.bits = '0;
      1:       r.bits = '1;
      default: r.bits = FontBits'($urandom_range(0, 255));
    endcase
    r.idx  = IdxBits'($urandom_range(0, 31));
    r.wide = 1'($urandom_range(0, 1));
    r.orow = pick_origin(32'(sb.panel_w));
    r.ocol = pick_origin(32'(sb.panel_h));
    return r;
  endfunction

  function automatic logic [PanelBits-1:0] random_panel();
    case ($urandom_range(0, 3))
      0:       return 11'd1024;
      1:       return PanelBits'($urandom_range(1, 16));
      default: return PanelBits'($urandom_range(1, 1024));
    endcase
  endfunction

  // APB write: setup cycle, then access cycle; the register takes the value
  // at the edge where pready is seen in the access phase.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [ColorBits-1:0] fg,
                                input logic [ColorBits-1:0] bg,
                                input logic bg_en, input logic [PanelBits-1:0] w,
                                input logic [PanelBits-1:0] h);
    write_reg(RegFgColor, 32'(fg));
    write_reg(RegBgColor, 32'(bg));
    write_reg(RegBgEnable, 32'(bg_en));
    write_reg(RegPanelW, 32'(w));
    write_reg(RegPanelH, 32'(h));
    settings_seen++;
  endtask

  // Offer one font request; called and returning at a falling edge. Valid
  // stays high into the next request when no gap is drawn.
  task automatic send_byte(input font_req_t req);
    int unsigned gap;
    // every third stretch of 20 requests runs back to back
    gap = ((sb.bytes_seen / 20) % 3 == 0) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      font_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    font_bits_i  <= req.bits;
    byte_index_i <= req.idx;
    wide_glyph_i <= req.wide;
    origin_row_i <= req.orow;
    origin_col_i <= req.ocol;
    font_valid_i <= 1'b1;
    do @(posedge clk_i); while (!font_ready_o);
    sb.expand_byte(req);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_byte(random_req());
  endtask

  // Stop offering, let every expected pixel arrive, then give swallowed
  // requests time to leave the pipe before anything else happens.
  task automatic drain();
    font_valid_i <= 1'b0;
    while (sb.due_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Pixel sink: draws a stall per pixel, with quiet stretches and one long
  // hold-off on request from the stimulus; checks each accepted pixel.
  initial begin : pixel_sink
    int unsigned gap;
    pixel_t      got;
    pixel_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_pixels) begin
        hold_pixels = 1'b0;
        gap = LongHoldCycles;
      end else if ((sb.pixels_seen / 25) % 3 == 0) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 14);
      end
      if (gap != 0) begin
        pixel_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pixel_ready_i <= 1'b1;
      do @(posedge clk_i); while (!pixel_valid_o);
      got.row   = pixel_row_o;
      got.col   = pixel_col_o;
      got.color = pixel_color_o;
      got.last  = last_pixel_o;
      sb.take_pixel(got);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    font_valid_i = 1'b0;
    font_bits_i  = '0;
    byte_index_i = '0;
    wide_glyph_i = 1'b0;
    origin_row_i = '0;
    origin_col_i = '0;
    sb = new();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: 240 x 320 panel, background painted
    send_byte(make_req(8'h00, 0, 0, 0, 0));        // all background
    send_byte(make_req(8'hFF, 0, 0, 0, 0));        // all foreground
    send_byte(make_req(8'h80, 15, 0, 0, 0));
    send_byte(make_req(8'h01, 31, 0, 0, 0));       // narrow, index past 15
    send_byte(make_req(8'hA5, 1, 1, 0, 0));        // wide, right half
    send_byte(make_req(8'h5A, 31, 1, 100, 200));
    send_byte(make_req(8'hFF, 0, 0, 239, 0));      // bottom row still on
    send_byte(make_req(8'hFF, 0, 0, 240, 0));      // one row too far
    send_byte(make_req(8'hC3, 0, 0, 0, 316));      // clipped at the column limit
    send_byte(make_req(8'hFF, 31, 1, 1023, 1023)); // coordinate overflow
    drain();

    // Opposite colours, transparent background, full 1024 panel
    write_settings(16'hFFFF, 16'h0000, 1'b0, 11'd1024, 11'd1024);
    send_byte(make_req(8'h00, 0, 0, 0, 0));        // transparent: nothing
    send_byte(make_req(8'h81, 0, 0, 1023, 1016));
    send_byte(make_req(8'hFF, 31, 1, 1008, 1008));
    send_byte(make_req(8'h55, 17, 0, 1000, 0));
    // receiver goes quiet for a long while as random traffic starts
    hold_pixels = 1'b1;
    send_random(60);
    drain();

    // Zero panel: nothing may come out
    write_settings(16'h1234, 16'hABCD, 1'b1, 11'd0, 11'd0);
    send_byte(make_req(8'hFF, 0, 0, 0, 0));
    send_byte(make_req(8'h00, 0, 0, 0, 0));
    send_random(10);
    drain();

    // Panel wider than the coordinate map: overflow alone drops pixels
    write_settings(ColorBits'($urandom_range(0, 65535)), ColorBits'($urandom_range(0, 65535)),
                   1'b1, 11'd2047, 11'd2047);
    send_byte(make_req(8'hFF, 5, 0, 1020, 0));
    send_byte(make_req(8'hFF, 0, 0, 0, 1020));
    send_byte(make_req(8'hFF, 1, 1, 0, 1015));
    send_random(30);
    drain();

    // Single-pixel panel
    write_settings(ColorBits'($urandom_range(0, 65535)), ColorBits'($urandom_range(0, 65535)),
                   1'b1, 11'd1, 11'd1);
    send_byte(make_req(8'h80, 0, 0, 0, 0));
    send_byte(make_req(8'h00, 0, 0, 0, 0));
    send_random(20);

    // Random settings; in one phase the sender stops midway until all is out
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_settings(ColorBits'($urandom_range(0, 65535)), ColorBits'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), random_panel(), random_panel());
      send_random(20);
      if (ph == 1) drain();
      send_random(20);
    end
    drain();

    $display("Covered %0d font requests and %0d pixel writes over %0d register settings,",
             sb.bytes_seen, sb.pixels_seen, settings_seen + 1);
    $display("panel sizes 0, 1, random, 1024 and 2047, both glyph widths, with a long output stall.");
    if (sb.errors == 0 && sb.due_pixels.size() == 0) begin
      $display("PASS font_glyph_row_expander_top");
    end else begin
      $display("FAIL font_glyph_row_expander_top");
    end
    $finish;
  end

endmodule
